>>> rtl/core/aetp_pkg.sv
// Shared types, codes and color tables for the ANSI escape text parser.
package aetp_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_IDX_PASSTHROUGH = 1'b0;

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;
   localparam logic [7:0] BYTE_SEMI  = 8'h3B;
   localparam logic [7:0] BYTE_UC_A  = 8'h41;
   localparam logic [7:0] BYTE_UC_Z  = 8'h5A;
   localparam logic [7:0] BYTE_LC_A  = 8'h61;
   localparam logic [7:0] BYTE_LC_Z  = 8'h7A;
   localparam logic [7:0] BYTE_SGR   = 8'h6D;  // 'm'
   localparam logic [7:0] BYTE_CUP   = 8'h48;  // 'H'
   localparam logic [7:0] BYTE_ED    = 8'h4A;  // 'J'

   localparam logic [3:0] DEFAULT_FG = 4'd7;
   localparam logic [3:0] DEFAULT_BG = 4'd0;
   localparam logic [31:0] COORD_MAX = 32'd65534;

   localparam logic [3:0] BASE_COLORS [8] = '{4'd0, 4'd4, 4'd2, 4'd6,
                                              4'd1, 4'd5, 4'd3, 4'd7};
   localparam logic [3:0] BRIGHT_COLORS [8] = '{4'd8, 4'd12, 4'd10, 4'd14,
                                                4'd9, 4'd13, 4'd11, 4'd15};

   typedef enum logic [1:0] {
      ACT_PRINT = 2'd0,
      ACT_COLOR = 2'd1,
      ACT_MOVE  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_READ  = 2'd1,
      ST_APPLY = 2'd2
   } state_type;

   typedef enum logic [2:0] {
      PF_NONE  = 3'd0,
      PF_CLEAR = 3'd1,
      PF_OPEN  = 3'd2,
      PF_DIGIT = 3'd3,
      PF_NEXT  = 3'd4
   } pf_op_type;

   typedef struct packed {
      pf_op_type  op;
      logic [3:0] digit;
   } pf_cmd_type;

   typedef struct packed {
      logic [3:0] fg;
      logic [3:0] bg;
   } colors_type;

   // One SGR code applied to the current colors; unknown codes leave them as is.
   function automatic colors_type apply_sgr(input logic [31:0] code,
                                            input colors_type cur);
      colors_type res;
      logic [31:0] off;
      res = cur;
      off = '0;
      if (code == 32'd0) begin
         res.fg = DEFAULT_FG;
         res.bg = DEFAULT_BG;
      end else if (code >= 32'd30 && code <= 32'd37) begin
         off = code - 32'd30;
         res.fg = BASE_COLORS[off[2:0]];
      end else if (code >= 32'd90 && code <= 32'd97) begin
         off = code - 32'd90;
         res.fg = BRIGHT_COLORS[off[2:0]];
      end else if (code >= 32'd40 && code <= 32'd47) begin
         off = code - 32'd40;
         res.bg = BASE_COLORS[off[2:0]];
      end else if (code >= 32'd100 && code <= 32'd107) begin
         off = code - 32'd100;
         res.bg = BRIGHT_COLORS[off[2:0]];
      end
      return res;
   endfunction

endpackage

>>> rtl/core/ansi_escape_text_parser.sv
// Top level of the ANSI escape text parser: byte decode, SGR sequencer, result register.
//
// Usage: text bytes enter on the req_ channel (req_start_of_string marks the first
// byte of a string), one beat per byte. Results leave on the rsp_ channel, at most
// one beat per byte: a printed character, a color update, a cursor move or a clear.
// csr_ is an APB-style port with one register at byte address 0 (bit 0:
// passthrough mode); write it only while the block is idle.
// Order of work: a byte that prints, moves the cursor or clears has its result
// registered in the result register as it is accepted. An SGR ('m') final byte walks the
// stored parameters through one read port of the parameter memory and one shared
// SGR decoder, in two steps per parameter (read, apply), before the color beat is
// shown. Bytes that only update parse state give no beat.
// req_ready is low while the SGR walk runs, and while a result beat waits and
// rsp_ready is low; a stalled receiver therefore holds the input side as well.
// Reset (synchronous, active high) clears the parse state, the stop flag and
// passthrough mode and sets colors to foreground 7, background 0; the parameter
// memory needs no clearing pass, since only slots written in the current sequence
// are ever read.
module ansi_escape_text_parser #(
   parameter int unsigned MAX_PARAMS = 16,
   parameter int unsigned PARAM_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_start_of_string,
   input  logic [7:0]                        req_text_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_action_kind,
   output logic [7:0]                        rsp_char_code,
   output logic [3:0]                        rsp_fg_index,
   output logic [3:0]                        rsp_bg_index,
   output logic [15:0]                       rsp_cursor_column,
   output logic [15:0]                       rsp_cursor_row,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aetp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   localparam int unsigned IW = $clog2(MAX_PARAMS);

   aetp_pkg::state_type   state_ff, state_in;
   logic                  in_esc_ff, in_esc_in;
   logic                  stopped_ff, stopped_in;
   logic                  pass_ff;
   logic [3:0]            fg_ff, fg_in;
   logic [3:0]            bg_ff, bg_in;
   logic [IW-1:0]         walk_ff, walk_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   aetp_pkg::action_type  kind_ff, kind_in;
   logic [7:0]            char_ff, char_in;
   logic [3:0]            rfg_ff, rfg_in;
   logic [3:0]            rbg_ff, rbg_in;
   logic [15:0]           col_ff, col_in;
   logic [15:0]           row_ff, row_in;

   aetp_pkg::pf_cmd_type  pf_cmd;
   logic [PARAM_BITS-1:0] pf_rd_data;
   logic [IW-1:0]         pf_idx;
   logic [PARAM_BITS-1:0] pf_p0;
   logic [PARAM_BITS-1:0] pf_p1;

   aetp_pkg::colors_type  sgr_colors;

   logic accept, stopped_eff, esc_eff, is_nul, is_digit, is_semi, is_alpha;
   logic live, parse, esc_open, print_go, in_seq, fin, sgr_go, cup_go, clr_go;
   logic walk_done, csr_wr, csr_hit;

   function automatic logic [15:0] zero_based(input logic [PARAM_BITS-1:0] v);
      logic [31:0] w;
      w = (v == '0) ? 32'd0 : (32'(v) - 32'd1);
      if (w > aetp_pkg::COORD_MAX) begin
         w = aetp_pkg::COORD_MAX;
      end
      return w[15:0];
   endfunction

   // ---- byte decode ----
   assign req_ready   = (state_ff == aetp_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept      = req_valid && req_ready;
   assign stopped_eff = stopped_ff && !req_start_of_string;
   assign esc_eff     = in_esc_ff && !req_start_of_string;
   assign is_nul      = (req_text_byte == aetp_pkg::BYTE_NUL);
   assign is_digit    = (req_text_byte >= aetp_pkg::BYTE_ZERO) &&
                        (req_text_byte <= aetp_pkg::BYTE_NINE);
   assign is_semi     = (req_text_byte == aetp_pkg::BYTE_SEMI);
   assign is_alpha    = ((req_text_byte >= aetp_pkg::BYTE_UC_A) &&
                         (req_text_byte <= aetp_pkg::BYTE_UC_Z)) ||
                        ((req_text_byte >= aetp_pkg::BYTE_LC_A) &&
                         (req_text_byte <= aetp_pkg::BYTE_LC_Z));

   assign live     = accept && !stopped_eff && !is_nul;
   assign parse    = live && !pass_ff;
   assign esc_open = parse && !esc_eff && (req_text_byte == aetp_pkg::BYTE_ESC);
   assign print_go = live && (pass_ff ||
                     (!esc_eff && (req_text_byte != aetp_pkg::BYTE_ESC)));
   assign in_seq   = parse && esc_eff;
   assign fin      = in_seq && is_alpha;
   assign sgr_go   = fin && (req_text_byte == aetp_pkg::BYTE_SGR);
   assign cup_go   = fin && (req_text_byte == aetp_pkg::BYTE_CUP);
   assign clr_go   = fin && (req_text_byte == aetp_pkg::BYTE_ED) &&
                     (pf_p0 == PARAM_BITS'(2));

   assign walk_done  = (walk_ff == pf_idx);
   assign sgr_colors = aetp_pkg::apply_sgr(32'(pf_rd_data),
                                           aetp_pkg::colors_type'({fg_ff, bg_ff}));

   aetp_param_file #(
      .MAX_PARAMS (MAX_PARAMS),
      .PARAM_BITS (PARAM_BITS)
   ) u_param_file (
      .clock   (clock),
      .reset   (reset),
      .cmd     (pf_cmd),
      .rd_addr (walk_ff),
      .rd_data (pf_rd_data),
      .idx     (pf_idx),
      .p0      (pf_p0),
      .p1      (pf_p1)
   );

   // ---- sequencer next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aetp_pkg::ST_IDLE: begin
            if (sgr_go) begin
               state_in = aetp_pkg::ST_READ;
            end
         end
         aetp_pkg::ST_READ: begin
            state_in = aetp_pkg::ST_APPLY;
         end
         aetp_pkg::ST_APPLY: begin
            state_in = walk_done ? aetp_pkg::ST_IDLE : aetp_pkg::ST_READ;
         end
         default: begin
            state_in = aetp_pkg::ST_IDLE;
         end
      endcase
   end

   // ---- datapath and result register ----
   always_comb begin
      in_esc_in    = in_esc_ff;
      stopped_in   = stopped_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      char_in      = char_ff;
      rfg_in       = rfg_ff;
      rbg_in       = rbg_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pf_cmd.op    = aetp_pkg::PF_NONE;
      pf_cmd.digit = 4'(req_text_byte - aetp_pkg::BYTE_ZERO);

      if (accept && req_start_of_string) begin
         in_esc_in  = 1'b0;
         stopped_in = 1'b0;
      end
      if (accept && !stopped_eff && is_nul) begin
         stopped_in = 1'b1;
      end
      if (esc_open) begin
         in_esc_in = 1'b1;
      end
      if (fin) begin
         in_esc_in = 1'b0;
      end

      priority if (esc_open) begin
         pf_cmd.op = aetp_pkg::PF_OPEN;
      end else if (accept && req_start_of_string) begin
         pf_cmd.op = aetp_pkg::PF_CLEAR;
      end else if (in_seq && is_digit) begin
         pf_cmd.op = aetp_pkg::PF_DIGIT;
      end else if (in_seq && is_semi) begin
         pf_cmd.op = aetp_pkg::PF_NEXT;
      end else begin
         pf_cmd.op = aetp_pkg::PF_NONE;
      end

      if (print_go || cup_go || clr_go) begin
         rsp_valid_in = 1'b1;
         char_in      = 8'd0;
         rfg_in       = fg_ff;
         rbg_in       = bg_ff;
         col_in       = 16'd0;
         row_in       = 16'd0;
         if (print_go) begin
            kind_in = aetp_pkg::ACT_PRINT;
            char_in = req_text_byte;
         end else if (cup_go) begin
            kind_in = aetp_pkg::ACT_MOVE;
            row_in  = zero_based(pf_p0);
            col_in  = zero_based((pf_idx != '0) ? pf_p1 : '0);
         end else begin
            kind_in = aetp_pkg::ACT_CLEAR;
         end
      end

      if (sgr_go) begin
         walk_in = '0;
      end

      if (state_ff == aetp_pkg::ST_APPLY) begin
         fg_in = sgr_colors.fg;
         bg_in = sgr_colors.bg;
         if (walk_done) begin
            rsp_valid_in = 1'b1;
            kind_in      = aetp_pkg::ACT_COLOR;
            char_in      = 8'd0;
            rfg_in       = sgr_colors.fg;
            rbg_in       = sgr_colors.bg;
            col_in       = 16'd0;
            row_in       = 16'd0;
         end else begin
            walk_in = walk_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aetp_pkg::ST_IDLE;
         in_esc_ff    <= 1'b0;
         stopped_ff   <= 1'b0;
         fg_ff        <= aetp_pkg::DEFAULT_FG;
         bg_ff        <= aetp_pkg::DEFAULT_BG;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_esc_ff    <= in_esc_in;
         stopped_ff   <= stopped_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      rfg_ff  <= rfg_in;
      rbg_ff  <= rbg_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
   end

   // ---- configuration port ----
   assign csr_hit = (csr_paddr[2:2] == aetp_pkg::CSR_IDX_PASSTHROUGH);
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
      end else if (csr_wr && csr_hit) begin
         pass_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = csr_hit ? {31'd0, pass_ff} : 32'd0;
   assign csr_pready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action_kind   = kind_ff;
   assign rsp_char_code     = char_ff;
   assign rsp_fg_index      = rfg_ff;
   assign rsp_bg_index      = rbg_ff;
   assign rsp_cursor_column = col_ff;
   assign rsp_cursor_row    = row_ff;

   walk_within_params: assert property (@(posedge clock) disable iff (reset)
      (state_ff != aetp_pkg::ST_IDLE) |-> (walk_ff <= pf_idx))
      else $error("SGR walk past last parameter");

   busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != aetp_pkg::ST_IDLE) |-> !req_ready)
      else $error("input taken during SGR walk");

   sgr_starts_walk: assert property (@(posedge clock) disable iff (reset)
      sgr_go |=> (state_ff == aetp_pkg::ST_READ && walk_ff == '0))
      else $error("SGR final byte did not start walk");

   stopped_is_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && stopped_ff && !req_start_of_string) |=> !rsp_valid_ff)
      else $error("result beat from a stopped string");

endmodule

>>> rtl/core/aetp_param_file.sv
// Escape parameter store: digit accumulator, parameter memory and shadow copies.
module aetp_param_file #(
   parameter int unsigned MAX_PARAMS = 16,
   parameter int unsigned PARAM_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aetp_pkg::pf_cmd_type          cmd,
   input  logic [$clog2(MAX_PARAMS)-1:0] rd_addr,
   output logic [PARAM_BITS-1:0]         rd_data,
   output logic [$clog2(MAX_PARAMS)-1:0] idx,
   output logic [PARAM_BITS-1:0]         p0,
   output logic [PARAM_BITS-1:0]         p1
);
   localparam int unsigned IW = $clog2(MAX_PARAMS);
   localparam int unsigned AW = PARAM_BITS + 4;

   logic [PARAM_BITS-1:0] mem [MAX_PARAMS];
   logic [PARAM_BITS-1:0] rd_data_ff;

   logic [IW-1:0]         idx_ff, idx_in;
   logic [PARAM_BITS-1:0] cur_ff, cur_in;
   logic [PARAM_BITS-1:0] p0_ff, p0_in;
   logic [PARAM_BITS-1:0] p1_ff, p1_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [PARAM_BITS-1:0] wr_data;

   logic [AW-1:0]         prod;
   logic [PARAM_BITS-1:0] acc;
   logic                  last;

   // cur * 10 + digit as two shifts and two adds, then saturate
   assign prod = (AW'(cur_ff) << 3) + (AW'(cur_ff) << 1) + AW'(cmd.digit);
   assign acc  = (prod[AW-1:PARAM_BITS] != '0) ? '1 : prod[PARAM_BITS-1:0];
   assign last = (idx_ff == IW'(MAX_PARAMS - 1));

   always_comb begin
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      p0_in   = p0_ff;
      p1_in   = p1_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = acc;
      unique case (cmd.op)
         aetp_pkg::PF_NONE: begin
         end
         aetp_pkg::PF_CLEAR: begin
            idx_in = '0;
            cur_in = '0;
            p0_in  = '0;
            p1_in  = '0;
         end
         aetp_pkg::PF_OPEN: begin
            idx_in  = '0;
            cur_in  = '0;
            p0_in   = '0;
            p1_in   = '0;
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '0;
         end
         aetp_pkg::PF_DIGIT: begin
            cur_in = acc;
            wr_en  = 1'b1;
            if (idx_ff == IW'(0)) begin
               p0_in = acc;
            end
            if (idx_ff == IW'(1)) begin
               p1_in = acc;
            end
         end
         aetp_pkg::PF_NEXT: begin
            // past the last slot a separator is dropped
            if (!last) begin
               idx_in  = idx_ff + IW'(1);
               cur_in  = '0;
               wr_en   = 1'b1;
               wr_addr = idx_ff + IW'(1);
               wr_data = '0;
               if (idx_ff == IW'(0)) begin
                  p1_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cur_ff <= '0;
         p0_ff  <= '0;
         p1_ff  <= '0;
      end else begin
         idx_ff <= idx_in;
         cur_ff <= cur_in;
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign idx     = idx_ff;
   assign p0      = p0_ff;
   assign p1      = p1_ff;

   idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IW'(MAX_PARAMS - 1))
      else $error("parameter index past last slot");

   cur_tracks_p0: assert property (@(posedge clock) disable iff (reset)
      (idx_ff == IW'(0)) |-> (cur_ff == p0_ff))
      else $error("accumulator and first parameter disagree");

   next_clears_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == aetp_pkg::PF_NEXT && !last) |=> (cur_ff == '0))
      else $error("new parameter slot not cleared");

endmodule
